>>> rtl/format_string_printer_macros.svh
// assertion macros for the format string printer
// used by rtl/format_string_printer.sv, no other dependencies
`ifndef FORMAT_STRING_PRINTER_MACROS_SVH
`define FORMAT_STRING_PRINTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsp assertion failed");
`define FSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsp assertion failed");
`else
`define FSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/fsp_pkg.sv
// types, codes and character constants of the format string printer
// no dependencies
`default_nettype none

package fsp_pkg;

    localparam int OP_W       = 2;
    localparam int NUM_W      = 32;
    localparam int COUNT_W    = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    localparam logic [OP_W-1:0] OP_FMT = 2'd0;
    localparam logic [OP_W-1:0] OP_NUM = 2'd1;
    localparam logic [OP_W-1:0] OP_STR = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [3:0] DEC_BASE = 4'd10;

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_PCT   = 3'd1,
        M_NUM_D = 3'd2,
        M_NUM_U = 3'd3,
        M_NUM_X = 3'd4,
        M_NUM_C = 3'd5,
        M_STR   = 3'd6
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // ascii of one decimal or hex digit, lower case
    function automatic logic [7:0] f_digit_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < DEC_BASE) begin
            ch = CH_ZERO + {4'd0, nib};
        end else begin
            ch = CH_LOW_A + {4'd0, nib - DEC_BASE};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/format_string_printer.sv
// format string printer: printf subset with %d %u %x %c %s and %%
// depends on rtl/fsp_pkg.sv and rtl/format_string_printer_macros.svh
//
//  channel   dir  tdata                                  tuser
//  s_axis    in   byte_value[7:0] number_value[39:8]     operation[1:0]
//  m_axis    out  char_out[7:0] total_length[39:8]       is_total[0] protocol_error[1]
//
// plain bytes, string bytes, %c, %% and totals: one item per cycle while not stalled
// %d / %u: an accept step, then the bit-serial bcd converter takes one argument bit
// per cycle, then leading zero digits are skipped and the digits are emitted
// %x: an accept step, then leading zero nibbles are skipped and the digits are emitted
// output stalls hold the digit emitter; no clearing pass after reset
`default_nettype none

`include "format_string_printer_macros.svh"

module format_string_printer #(
    parameter int ARG_WIDTH = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // byte_value, number_value
    input  wire  [fsp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // operation
    input  wire  [fsp_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // char_out, total_length
    output logic [fsp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // is_total, protocol_error
    output logic [fsp_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    output logic                                m_axis_tlast
);

    localparam int  VW  = (ARG_WIDTH < fsp_pkg::NUM_W) ? ARG_WIDTH : fsp_pkg::NUM_W;
    localparam bit  SGN = (ARG_WIDTH <= fsp_pkg::NUM_W);
    localparam int  ND  = ((VW * 1233) >> 12) + 1;
    localparam int  NH  = (VW + 3) / 4;
    localparam int  NN  = (ND > NH) ? ND : NH;
    localparam int  BW  = 4 * NN;
    localparam int  BCW = $clog2(VW + 1);
    localparam int  DCW = $clog2(NN + 1);

    fsp_pkg::t_state                    r_state, n_state;
    fsp_pkg::t_mode                     r_mode, n_mode;
    logic [fsp_pkg::COUNT_W-1:0]        r_count, n_count;
    logic [VW-1:0]                      r_bin, n_bin;
    logic [BW-1:0]                      r_dig, n_dig;
    logic [BCW-1:0]                     r_bit_cnt, n_bit_cnt;
    logic [DCW-1:0]                     r_dig_cnt, n_dig_cnt;
    logic                               r_m_tvalid, n_m_tvalid;
    logic [fsp_pkg::OUT_DATA_W-1:0]     r_m_tdata, n_m_tdata;
    logic [fsp_pkg::OUT_USER_W-1:0]     r_m_tuser, n_m_tuser;
    logic                               r_m_tlast, n_m_tlast;

    logic [fsp_pkg::OP_W-1:0]           w_op;
    logic [7:0]                         w_byte;
    logic [fsp_pkg::NUM_W-1:0]          w_num;
    logic [VW-1:0]                      w_val;
    logic                               w_neg;
    logic [VW-1:0]                      w_mag;
    logic                               w_slot;
    logic                               w_acc;
    logic                               w_wait_num;
    logic [BW-1:0]                      w_dab;
    logic [3:0]                         w_top;

    logic                               e_valid;
    logic [7:0]                         e_char;
    logic                               e_total;
    logic                               e_err;
    logic                               e_last;

    // add three to every bcd digit of five or more
    function automatic logic [BW-1:0] f_dabble(input logic [BW-1:0] d);
        logic [BW-1:0] q;
        q = d;
        for (int i = 0; i < NN; i++) begin
            if (d[4*i +: 4] > 4'd4) begin
                q[4*i +: 4] = d[4*i +: 4] + 4'd3;
            end
        end
        return q;
    endfunction

    assign w_op       = s_axis_tuser;
    assign w_byte     = s_axis_tdata[7:0];
    assign w_num      = s_axis_tdata[39:8];
    assign w_val      = w_num[VW-1:0];
    assign w_neg      = SGN && w_val[VW-1];
    assign w_mag      = w_neg ? (~w_val + {{(VW-1){1'b0}}, 1'b1}) : w_val;
    assign w_slot     = !r_m_tvalid || m_axis_tready;
    assign w_acc      = s_axis_tvalid && s_axis_tready;
    assign w_wait_num = (r_mode == fsp_pkg::M_NUM_D) || (r_mode == fsp_pkg::M_NUM_U) ||
                        (r_mode == fsp_pkg::M_NUM_X) || (r_mode == fsp_pkg::M_NUM_C);
    assign w_dab      = f_dabble(r_dig);
    assign w_top      = r_dig[BW-1 -: 4];

    assign s_axis_tready = (r_state == fsp_pkg::S_IDLE) && w_slot;
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;
    assign m_axis_tlast  = r_m_tlast;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_count    = r_count;
        n_bin      = r_bin;
        n_dig      = r_dig;
        n_bit_cnt  = r_bit_cnt;
        n_dig_cnt  = r_dig_cnt;
        n_m_tvalid = r_m_tvalid && !m_axis_tready;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;
        n_m_tlast  = r_m_tlast;
        e_valid    = 1'b0;
        e_char     = fsp_pkg::CH_NUL;
        e_total    = 1'b0;
        e_err      = 1'b0;
        e_last     = 1'b1;

        unique case (r_state)
            fsp_pkg::S_IDLE: begin
                if (w_acc) begin
                    priority if (w_op == fsp_pkg::OP_FMT && !w_wait_num &&
                                 r_mode != fsp_pkg::M_STR) begin
                        if (r_mode == fsp_pkg::M_PCT) begin
                            n_mode = fsp_pkg::M_IDLE;
                            unique case (w_byte)
                                fsp_pkg::CH_D:   n_mode = fsp_pkg::M_NUM_D;
                                fsp_pkg::CH_U:   n_mode = fsp_pkg::M_NUM_U;
                                fsp_pkg::CH_X:   n_mode = fsp_pkg::M_NUM_X;
                                fsp_pkg::CH_C:   n_mode = fsp_pkg::M_NUM_C;
                                fsp_pkg::CH_S:   n_mode = fsp_pkg::M_STR;
                                fsp_pkg::CH_NUL: begin
                                    e_valid = 1'b1;
                                    e_total = 1'b1;
                                end
                                default: begin
                                    e_valid = 1'b1;
                                    e_char  = w_byte;
                                end
                            endcase
                        end else if (w_byte == fsp_pkg::CH_NUL) begin
                            n_mode  = fsp_pkg::M_IDLE;
                            e_valid = 1'b1;
                            e_total = 1'b1;
                        end else if (w_byte == fsp_pkg::CH_PCT) begin
                            n_mode = fsp_pkg::M_PCT;
                        end else begin
                            e_valid = 1'b1;
                            e_char  = w_byte;
                        end
                    end else if (w_op == fsp_pkg::OP_NUM && w_wait_num) begin
                        n_mode = fsp_pkg::M_IDLE;
                        if (r_mode == fsp_pkg::M_NUM_C) begin
                            e_valid = 1'b1;
                            e_char  = w_num[7:0];
                        end else if (r_mode == fsp_pkg::M_NUM_X) begin
                            n_dig     = BW'(w_val);
                            n_dig_cnt = DCW'(NN);
                            n_state   = fsp_pkg::S_SKIP;
                        end else begin
                            if (r_mode == fsp_pkg::M_NUM_D && w_neg) begin
                                e_valid = 1'b1;
                                e_char  = fsp_pkg::CH_MINUS;
                                e_last  = 1'b0;
                                n_bin   = w_mag;
                            end else begin
                                n_bin   = w_val;
                            end
                            n_dig     = '0;
                            n_bit_cnt = BCW'(VW);
                            n_state   = fsp_pkg::S_CONV;
                        end
                    end else if (w_op == fsp_pkg::OP_STR && r_mode == fsp_pkg::M_STR) begin
                        if (w_byte == fsp_pkg::CH_NUL) begin
                            n_mode = fsp_pkg::M_IDLE;
                        end else begin
                            e_valid = 1'b1;
                            e_char  = w_byte;
                        end
                    end else begin
                        e_valid = 1'b1;
                        e_err   = 1'b1;
                    end
                end
            end
            fsp_pkg::S_CONV: begin
                n_dig     = {w_dab[BW-2:0], r_bin[VW-1]};
                n_bin     = r_bin << 1;
                n_bit_cnt = r_bit_cnt - BCW'(1);
                if (r_bit_cnt == BCW'(1)) begin
                    n_dig_cnt = DCW'(NN);
                    n_state   = fsp_pkg::S_SKIP;
                end
            end
            fsp_pkg::S_SKIP: begin
                if (w_top == 4'd0 && r_dig_cnt > DCW'(1)) begin
                    n_dig     = r_dig << 4;
                    n_dig_cnt = r_dig_cnt - DCW'(1);
                end else begin
                    n_state = fsp_pkg::S_EMIT;
                end
            end
            fsp_pkg::S_EMIT: begin
                if (w_slot) begin
                    e_valid   = 1'b1;
                    e_char    = fsp_pkg::f_digit_char(w_top);
                    e_last    = (r_dig_cnt == DCW'(1));
                    n_dig     = r_dig << 4;
                    n_dig_cnt = r_dig_cnt - DCW'(1);
                    if (r_dig_cnt == DCW'(1)) begin
                        n_state = fsp_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = fsp_pkg::S_IDLE;
        endcase

        if (e_valid) begin
            n_m_tvalid = 1'b1;
            n_m_tlast  = e_last;
            n_m_tuser  = {e_err, e_total};
            if (e_total) begin
                n_m_tdata = {r_count, fsp_pkg::CH_NUL};
                n_count   = '0;
            end else begin
                n_m_tdata = {{fsp_pkg::COUNT_W{1'b0}}, e_char};
                if (!e_err && r_count != {fsp_pkg::COUNT_W{1'b1}}) begin
                    n_count = r_count + fsp_pkg::COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fsp_pkg::S_IDLE;
            r_mode     <= fsp_pkg::M_IDLE;
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
            r_bit_cnt  <= '0;
            r_dig_cnt  <= '0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_count    <= n_count;
            r_m_tvalid <= n_m_tvalid;
            r_bit_cnt  <= n_bit_cnt;
            r_dig_cnt  <= n_dig_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_dig     <= n_dig;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
        r_m_tlast <= n_m_tlast;
    end

    // totals and errors carry no character and close their item
    `FSP_ASSERT_IMP(a_total_word, i_clk, i_rst_n,
        r_m_tvalid && r_m_tuser[0], r_m_tlast && r_m_tdata[7:0] == fsp_pkg::CH_NUL)
    `FSP_ASSERT_IMP(a_error_word, i_clk, i_rst_n,
        r_m_tvalid && r_m_tuser[1], r_m_tlast && r_m_tdata == '0)
    // number printing always returns to plain text parsing
    `FSP_ASSERT_IMP(a_mode_idle, i_clk, i_rst_n,
        r_state != fsp_pkg::S_IDLE, r_mode == fsp_pkg::M_IDLE)
    // a word that is not last means more digits are still coming
    `FSP_ASSERT_IMP(a_more_words, i_clk, i_rst_n,
        r_m_tvalid && !r_m_tlast, r_state != fsp_pkg::S_IDLE)
    `FSP_ASSERT_NXT(a_emit_count, i_clk, i_rst_n,
        r_state == fsp_pkg::S_SKIP, r_dig_cnt != '0)

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for format_string_printer: queue-fed stream driver,
// printf-subset predictor and field-by-field output checker
// depends on rtl/fsp_pkg.sv and rtl/format_string_printer.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 195;
    localparam int HOLD_AFTER = 90;
    localparam int HOLD_CYCLES = 400;

    // operation code outside the defined set
    localparam logic [fsp_pkg::OP_W-1:0] OP_BAD = 2'd3;

    typedef struct {
        logic [fsp_pkg::OP_W-1:0]  op;
        logic [7:0]                chr;
        logic [fsp_pkg::NUM_W-1:0] num;
        bit                        sync;
    } t_fmt_item;

    typedef struct {
        logic [7:0]                  chr;
        logic                        is_total;
        logic [fsp_pkg::COUNT_W-1:0] total;
        logic                        err;
        logic                        last;
    } t_printout;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [fsp_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic [fsp_pkg::OP_W-1:0]         s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [fsp_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic [fsp_pkg::OUT_USER_W-1:0]   m_axis_tuser;
    logic                             m_axis_tlast;

    t_fmt_item pending_items[$];
    t_printout expected_chars[$];

    fsp_pkg::t_mode              fmt_mode = fsp_pkg::M_IDLE;
    logic [fsp_pkg::COUNT_W-1:0] char_count = '0;

    int  mismatches = 0;
    int  accepted_items = 0;
    int  total_items = 0;
    int  cycles = 0;
    bit  sync_next = 0;
    bit  in_fire = 0;
    bit  out_fire = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    bit  tx_idle = 1;
    bit  rx_idle = 1;
    int  hold_left = 0;
    int  hold_seen = 0;
    bit  hold_done = 0;

    format_string_printer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor

    function automatic void push_word(input logic [7:0] c, input logic tot,
                                      input logic [fsp_pkg::COUNT_W-1:0] len,
                                      input logic err);
        t_printout r;
        r.chr = c;
        r.is_total = tot;
        r.total = len;
        r.err = err;
        r.last = 1'b0;
        expected_chars.push_back(r);
    endfunction

    function automatic void push_char(input logic [7:0] c);
        push_word(c, 1'b0, '0, 1'b0);
        if (char_count != '1)
            char_count = char_count + 1;
    endfunction

    function automatic void close_format();
        push_word(fsp_pkg::CH_NUL, 1'b1, char_count, 1'b0);
        char_count = '0;
        fmt_mode = fsp_pkg::M_IDLE;
    endfunction

    function automatic void push_decimal(input logic [fsp_pkg::NUM_W-1:0] mag);
        logic [7:0] digs[12];
        int n;
        n = 0;
        do begin
            digs[n] = fsp_pkg::CH_ZERO + 8'(mag % 10);
            mag = mag / 10;
            n++;
        end while (mag != 0);
        for (int i = n - 1; i >= 0; i--)
            push_char(digs[i]);
    endfunction

    function automatic void push_hex(input logic [fsp_pkg::NUM_W-1:0] v);
        logic [7:0] digs[12];
        logic [3:0] nib;
        int n;
        n = 0;
        do begin
            nib = v[3:0];
            digs[n] = (nib < 10) ? fsp_pkg::CH_ZERO + 8'(nib)
                                 : fsp_pkg::CH_LOW_A + 8'(nib) - 8'd10;
            v = v >> 4;
            n++;
        end while (v != 0);
        for (int i = n - 1; i >= 0; i--)
            push_char(digs[i]);
    endfunction

    function automatic void predict_printout(input logic [fsp_pkg::OP_W-1:0] op,
                                             input logic [7:0] b,
                                             input logic [fsp_pkg::NUM_W-1:0] num);
        int  first;
        bit  waiting;
        first = expected_chars.size();
        waiting = (fmt_mode == fsp_pkg::M_NUM_D) || (fmt_mode == fsp_pkg::M_NUM_U) ||
                  (fmt_mode == fsp_pkg::M_NUM_X) || (fmt_mode == fsp_pkg::M_NUM_C);
        if (op == fsp_pkg::OP_FMT && !waiting && fmt_mode != fsp_pkg::M_STR) begin
            if (fmt_mode == fsp_pkg::M_PCT) begin
                fmt_mode = fsp_pkg::M_IDLE;
                case (b)
                    fsp_pkg::CH_D: fmt_mode = fsp_pkg::M_NUM_D;
                    fsp_pkg::CH_U: fmt_mode = fsp_pkg::M_NUM_U;
                    fsp_pkg::CH_X: fmt_mode = fsp_pkg::M_NUM_X;
                    fsp_pkg::CH_C: fmt_mode = fsp_pkg::M_NUM_C;
                    fsp_pkg::CH_S: fmt_mode = fsp_pkg::M_STR;
                    fsp_pkg::CH_PCT: push_char(fsp_pkg::CH_PCT);
                    fsp_pkg::CH_NUL: close_format();
                    default: push_char(b);
                endcase
            end else if (b == fsp_pkg::CH_NUL) begin
                close_format();
            end else if (b == fsp_pkg::CH_PCT) begin
                fmt_mode = fsp_pkg::M_PCT;
            end else begin
                push_char(b);
            end
        end else if (op == fsp_pkg::OP_NUM && waiting) begin
            case (fmt_mode)
                fsp_pkg::M_NUM_D: begin
                    if (num[fsp_pkg::NUM_W-1]) begin
                        push_char(fsp_pkg::CH_MINUS);
                        push_decimal(-num);
                    end else begin
                        push_decimal(num);
                    end
                end
                fsp_pkg::M_NUM_U: push_decimal(num);
                fsp_pkg::M_NUM_X: push_hex(num);
                default: push_char(num[7:0]);
            endcase
            fmt_mode = fsp_pkg::M_IDLE;
        end else if (op == fsp_pkg::OP_STR && fmt_mode == fsp_pkg::M_STR) begin
            if (b == fsp_pkg::CH_NUL)
                fmt_mode = fsp_pkg::M_IDLE;
            else
                push_char(b);
        end else begin
            push_word(fsp_pkg::CH_NUL, 1'b0, '0, 1'b1);
        end
        if (expected_chars.size() > first)
            expected_chars[expected_chars.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // stimulus helpers

    task automatic add_item(input logic [fsp_pkg::OP_W-1:0] op, input logic [7:0] c,
                            input logic [fsp_pkg::NUM_W-1:0] n = '0);
        t_fmt_item it;
        it.op = op;
        it.chr = c;
        it.num = n;
        it.sync = sync_next;
        sync_next = 0;
        pending_items.push_back(it);
        total_items++;
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == fsp_pkg::CH_PCT);
        return c;
    endfunction

    // driver: one word in flight, gap drawn per item

    always @(negedge i_clk) begin
        t_fmt_item nxt;
        if (i_rst_n && !(s_axis_tvalid && !in_fire)) begin
            if (tx_gap != 0) begin
                tx_gap = tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].sync && expected_chars.size() != 0)) begin
                nxt = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= nxt.op;
                s_axis_tdata <= {nxt.num, nxt.chr};
                tx_gap = tx_idle ? $urandom_range(0, 15) : 0;
                if ($urandom_range(0, 31) == 0)
                    tx_idle = !tx_idle;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver with random stalls and one long hold-off

    always @(negedge i_clk) begin
        if (out_fire) begin
            rx_gap = rx_idle ? $urandom_range(0, 15) : 0;
            if ($urandom_range(0, 31) == 0)
                rx_idle = !rx_idle;
        end
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap = rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                hold_seen <= hold_seen + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (!hold_done && hold_seen == HOLD_AFTER) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1;
            end
        end
    end

    // monitor and checker

    always @(posedge i_clk) begin
        t_printout got;
        t_printout want;
        if (!i_rst_n) begin
            in_fire <= 0;
            out_fire <= 0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            out_fire <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_printout(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8]);
                accepted_items++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.chr = m_axis_tdata[7:0];
                got.total = m_axis_tdata[39:8];
                got.is_total = m_axis_tuser[0];
                got.err = m_axis_tuser[1];
                got.last = m_axis_tlast;
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected word char %h", got.chr));
                end else begin
                    want = expected_chars.pop_front();
                    if (got.chr !== want.chr)
                        report_mismatch($sformatf("char_out %h, want %h", got.chr, want.chr));
                    if (got.is_total !== want.is_total)
                        report_mismatch($sformatf("is_total %b, want %b",
                                                  got.is_total, want.is_total));
                    if (got.total !== want.total)
                        report_mismatch($sformatf("total_length %0d, want %0d",
                                                  got.total, want.total));
                    if (got.err !== want.err)
                        report_mismatch($sformatf("protocol_error %b, want %b",
                                                  got.err, want.err));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("format_string_printer test failed");
            $finish;
        end
    end

    initial begin
        int target;
        int seg;
        int len;

        // directed
        add_item(fsp_pkg::OP_FMT, 8'h41);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_D);
        add_item(fsp_pkg::OP_NUM, 8'h00, 32'h8000_0000);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_U);
        add_item(fsp_pkg::OP_NUM, 8'hff, 32'hffff_ffff);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_X);
        add_item(fsp_pkg::OP_NUM, 8'h00, 32'h0);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_C);
        add_item(fsp_pkg::OP_NUM, 8'h00, 32'h0);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_S);
        add_item(fsp_pkg::OP_STR, 8'hff);
        add_item(fsp_pkg::OP_STR, fsp_pkg::CH_NUL);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
        add_item(fsp_pkg::OP_FMT, 8'h71);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_NUL);
        add_item(fsp_pkg::OP_NUM, 8'h00, 32'h1234);
        add_item(OP_BAD, 8'hff, 32'hffff_ffff);
        add_item(fsp_pkg::OP_STR, 8'h41);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_D);
        add_item(fsp_pkg::OP_FMT, 8'h7a);
        add_item(fsp_pkg::OP_NUM, 8'h00, 32'd12345);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_S);
        add_item(fsp_pkg::OP_STR, fsp_pkg::CH_NUL);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_NUL);

        // random: mostly well-formed conversions, some noise
        target = total_items + RANDOM_ITEMS;
        sync_next = 1;
        while (total_items < target) begin
            if (total_items >= target - RANDOM_ITEMS / 2 &&
                total_items < target - RANDOM_ITEMS / 2 + 5)
                sync_next = 1;
            if ($urandom_range(0, 99) < 15) begin
                add_item(2'($urandom_range(0, 3)), 8'($urandom), $urandom);
            end else begin
                seg = $urandom_range(0, 9);
                if (seg <= 2) begin
                    add_item(fsp_pkg::OP_FMT, text_char());
                end else if (seg <= 6) begin
                    add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
                    case (seg)
                        3: add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_D);
                        4: add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_U);
                        5: add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_X);
                        default: add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_C);
                    endcase
                    case ($urandom_range(0, 5))
                        0: add_item(fsp_pkg::OP_NUM, 8'($urandom), 32'h0);
                        1: add_item(fsp_pkg::OP_NUM, 8'($urandom), 32'hffff_ffff);
                        2: add_item(fsp_pkg::OP_NUM, 8'($urandom), 32'h8000_0000);
                        default: add_item(fsp_pkg::OP_NUM, 8'($urandom),
                                          $urandom >> $urandom_range(0, 31));
                    endcase
                end else if (seg == 7) begin
                    add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
                    add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_S);
                    len = $urandom_range(0, 5);
                    repeat (len) add_item(fsp_pkg::OP_STR, text_char());
                    add_item(fsp_pkg::OP_STR, fsp_pkg::CH_NUL);
                end else if (seg == 8) begin
                    add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
                    add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_PCT);
                end else begin
                    add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_NUL);
                end
            end
        end
        add_item(fsp_pkg::OP_FMT, fsp_pkg::CH_NUL);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_items == total_items);
        wait (expected_chars.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("format_string_printer test passed");
        end else begin
            $display("format_string_printer test failed");
        end
        $finish;
    end

endmodule
